// ===== hw/rtl/uart_line_link_handshake_defines.svh =====
// assertion macros for the uart line link with handshake
// used by uart_line_link_handshake; expects clk and rst in scope
`ifndef UART_LINE_LINK_HANDSHAKE_DEFINES_SVH
`define UART_LINE_LINK_HANDSHAKE_DEFINES_SVH

// same-cycle implication
`define ULLH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ULLH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ullh_pkg.sv =====
// shared types and constants for the uart line link with handshake
// no dependencies
package ullh_pkg;

  localparam int ULLH_LINE_BYTES  = 32;
  localparam int ULLH_QUEUE_LINES = 4;

  localparam logic [15:0] PING_IVL_RST = 16'd1000;
  localparam logic [15:0] TIMEOUT_RST  = 16'd3000;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  localparam logic [1:0] REG_INITIATOR = 2'd0;
  localparam logic [1:0] REG_PING_IVL  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [2:0] TX_NONE = 3'd0;
  localparam logic [2:0] TX_PING = 3'd1;
  localparam logic [2:0] TX_PONG = 3'd2;
  localparam logic [2:0] TX_ACK  = 3'd3;
  localparam logic [2:0] TX_KA   = 3'd4;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_HASH = 8'h23;

  localparam logic [31:0] WORD_PING = 32'h50494E47;
  localparam logic [31:0] WORD_PONG = 32'h504F4E47;
  localparam logic [23:0] WORD_ACK  = 24'h41434B;
  localparam logic [15:0] WORD_KA   = 16'h4B41;

  typedef struct packed {
    logic tick;
    logic seen;
    logic ping_chk;
  } ullh_tmr_ctl_t;

endpackage

// ===== hw/rtl/ullh_timer.sv =====
// millisecond clock and link timers with one shared subtract and compare unit
// depends on ullh_pkg
module ullh_timer import ullh_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ullh_tmr_ctl_t ctl,
  input  logic [15:0]   ping_ivl,
  input  logic [15:0]   timeout,
  output logic          expired
);

  logic [31:0] ms_now;
  logic [31:0] last_ping;
  logic [31:0] last_seen;
  logic [31:0] ref_ms;
  logic [15:0] limit;
  logic [31:0] diff;

  assign ref_ms  = ctl.ping_chk ? last_ping : last_seen;
  assign limit   = ctl.ping_chk ? ping_ivl : timeout;
  assign diff    = ms_now - ref_ms;
  assign expired = (diff[31:16] != 16'd0) || (diff[15:0] > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_now    <= 32'd0;
      last_ping <= 32'd0;
      last_seen <= 32'd0;
    end else begin
      if (ctl.tick) begin
        ms_now <= ms_now + 32'd1;
      end
      if (ctl.seen) begin
        last_seen <= ms_now;
      end
      if (ctl.ping_chk && expired) begin
        last_ping <= ms_now;
      end
    end
  end

endmodule

// ===== hw/rtl/uart_line_link_handshake.sv =====
// steps: a byte goes to EMIT; a non-empty data line to COPY, then EMIT; a tick to TICK_P,
// TICK_S, then EMIT; a pop to POP_RD, POP_OUT per character (EMIT for an empty queue or
// empty line); EMIT and POP_OUT wait on output stall; one transaction at a time, set by
// the sequencer, the shared timer compare and the single-port line copy; results wait in
// an output register; reset: sync active high, clears link, line length, queue pointers
// and timers; line and queue memories are not cleared
`include "uart_line_link_handshake_defines.svh"

module uart_line_link_handshake import ullh_pkg::*; #(
  parameter int LINE_BYTES  = ULLH_LINE_BYTES,
  parameter int QUEUE_LINES = ULLH_QUEUE_LINES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_code, line_char, connected, lines_waiting, line_dropped
  output logic [0:0]  m_tuser,   // char_valid
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int LEN_W    = $clog2(LINE_BYTES);
  localparam int SLOT_W   = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
  localparam int CNT_W    = $clog2(QUEUE_LINES + 1);
  localparam int RX_DEPTH = 1 << LEN_W;
  localparam int Q_DEPTH  = 1 << (SLOT_W + LEN_W);
  localparam int QL_DEPTH = 1 << SLOT_W;
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(LINE_BYTES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_LINES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_LINES);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_COPY    = 3'd1;
  localparam logic [2:0] ST_TICK_P  = 3'd2;
  localparam logic [2:0] ST_TICK_S  = 3'd3;
  localparam logic [2:0] ST_POP_RD  = 3'd4;
  localparam logic [2:0] ST_POP_OUT = 3'd5;
  localparam logic [2:0] ST_EMIT    = 3'd6;

  logic [2:0] state;

  logic        initiator;
  logic [15:0] ping_ivl;
  logic [15:0] timeout;

  logic             link_up;
  logic [LEN_W-1:0] rx_length;
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       rx_head [4];
  logic [7:0]       rx_rd_data;

  logic [7:0]        qmem [Q_DEPTH];
  logic [LEN_W-1:0]  qlen [QL_DEPTH];
  logic [7:0]        q_rd_data;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] pslot;
  logic [CNT_W-1:0]  queue_count;

  logic [LEN_W-1:0] clen;
  logic [LEN_W-1:0] cidx;
  logic [LEN_W-1:0] cwidx;
  logic             cpend;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] pidx;

  logic [2:0] res_tx;
  logic       res_drop;

  logic [2:0] o_tx;
  logic [7:0] o_char;
  logic       o_cv;
  logic       o_last;
  logic       o_conn;
  logic [2:0] o_lines;
  logic       o_drop;

  logic accept;
  logic out_free;
  logic is_byte;
  logic is_lf;
  logic is_cr;
  logic [31:0] head_word;
  logic is_ping;
  logic is_pong;
  logic is_ack;
  logic is_ka;
  logic is_hash;
  logic q_full;
  logic data_line;
  logic rx_wr;
  logic rx_rd_en;
  logic q_wr;
  logic copy_last;
  logic q_commit;
  logic [LEN_W-1:0]  commit_len;
  logic [SLOT_W-1:0] tail_next;
  logic [SLOT_W-1:0] head_next;
  logic [LEN_W-1:0]  head_len;

  ullh_tmr_ctl_t tmr_ctl;
  logic          tmr_expired;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign is_byte   = (s_tuser == ACT_BYTE);
  assign is_lf     = (s_tdata == CHAR_LF);
  assign is_cr     = (s_tdata == CHAR_CR);
  assign head_word = {rx_head[0], rx_head[1], rx_head[2], rx_head[3]};
  assign is_ping   = (32'(rx_length) == 32'd4) && (head_word == WORD_PING);
  assign is_pong   = (32'(rx_length) == 32'd4) && (head_word == WORD_PONG);
  assign is_ack    = (32'(rx_length) == 32'd3) && (head_word[31:8] == WORD_ACK);
  assign is_ka     = (32'(rx_length) == 32'd2) && (head_word[31:16] == WORD_KA);
  assign is_hash   = (rx_length != '0) && (rx_head[0] == CHAR_HASH);
  assign q_full    = (queue_count == FULL_CNT);

  // line that goes to the queue rather than to the handshake; keep-alive and # lines are not queued
  assign data_line = !(!initiator && is_ping)
                  && !(initiator && is_pong && !link_up)
                  && !(!initiator && is_ack)
                  && !is_ka && !is_hash;

  assign rx_wr     = accept && is_byte && !is_cr && !is_lf && (rx_length < MAX_LEN);
  assign rx_rd_en  = (state == ST_COPY) && (cidx != clen);
  assign q_wr      = (state == ST_COPY) && cpend;
  assign copy_last = q_wr && (cwidx == clen - LEN_W'(1));
  assign q_commit  = copy_last
                  || (accept && is_byte && is_lf && data_line && !q_full && rx_length == '0);
  assign commit_len = (state == ST_COPY) ? clen : '0;

  assign tail_next = (tail == LAST_SLOT) ? '0 : tail + SLOT_W'(1);
  assign head_next = (head == LAST_SLOT) ? '0 : head + SLOT_W'(1);
  assign head_len  = qlen[head];

  assign tmr_ctl.tick     = accept && (s_tuser == ACT_TICK);
  assign tmr_ctl.seen     = accept && is_byte && is_lf;
  assign tmr_ctl.ping_chk = (state == ST_TICK_P);

  ullh_timer u_timer (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tmr_ctl),
    .ping_ivl (ping_ivl),
    .timeout  (timeout),
    .expired  (tmr_expired)
  );

  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_mem[rx_length] <= s_tdata;
    end
    if (rx_wr && (32'(rx_length) < 32'd4)) begin
      rx_head[rx_length[1:0]] <= s_tdata;
    end
    if (rx_rd_en) begin
      rx_rd_data <= rx_mem[cidx];
    end
    if (q_wr) begin
      qmem[{tail, cwidx}] <= rx_rd_data;
    end
    if (q_commit) begin
      qlen[tail] <= commit_len;
    end
    if (state == ST_POP_RD) begin
      q_rd_data <= qmem[{pslot, pidx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      initiator   <= 1'b0;
      ping_ivl    <= PING_IVL_RST;
      timeout     <= TIMEOUT_RST;
      link_up     <= 1'b0;
      rx_length   <= '0;
      head        <= '0;
      tail        <= '0;
      queue_count <= '0;
      cpend       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_INITIATOR: initiator <= cfg_wdata[0];
          REG_PING_IVL:  ping_ivl  <= cfg_wdata;
          REG_TIMEOUT:   timeout   <= cfg_wdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (q_commit) begin
        tail        <= tail_next;
        queue_count <= queue_count + CNT_W'(1);
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_tx   <= TX_NONE;
            res_drop <= 1'b0;
            state    <= ST_EMIT;
            priority if (is_byte) begin
              priority if (is_cr) begin
              end else if (is_lf) begin
                rx_length <= '0;
                priority if (!initiator && is_ping) begin
                  res_tx <= TX_PONG;
                end else if (initiator && is_pong && !link_up) begin
                  res_tx  <= TX_ACK;
                  link_up <= 1'b1;
                end else if (!initiator && is_ack) begin
                  link_up <= 1'b1;
                end else if (data_line) begin
                  if (q_full) begin
                    res_drop <= 1'b1;
                  end else if (rx_length != '0) begin
                    clen  <= rx_length;
                    cidx  <= '0;
                    cpend <= 1'b0;
                    state <= ST_COPY;
                  end
                end
              end else if (rx_length < MAX_LEN) begin
                rx_length <= rx_length + LEN_W'(1);
              end else begin
                rx_length <= '0;
              end
            end else if (s_tuser == ACT_TICK) begin
              state <= ST_TICK_P;
            end else if (s_tuser == ACT_POP) begin
              if (queue_count != '0) begin
                pslot       <= head;
                plen        <= head_len;
                pidx        <= '0;
                head        <= head_next;
                queue_count <= queue_count - CNT_W'(1);
                if (head_len != '0) begin
                  state <= ST_POP_RD;
                end
              end
            end
          end
        end
        ST_COPY: begin
          cpend <= rx_rd_en;
          cwidx <= cidx;
          if (rx_rd_en) begin
            cidx <= cidx + LEN_W'(1);
          end
          if (copy_last) begin
            cpend <= 1'b0;
            state <= ST_EMIT;
          end
        end
        ST_TICK_P: begin
          if (tmr_expired) begin
            res_tx <= link_up ? TX_KA : (initiator ? TX_PING : TX_NONE);
          end
          state <= ST_TICK_S;
        end
        ST_TICK_S: begin
          if (link_up && tmr_expired) begin
            link_up <= 1'b0;
          end
          state <= ST_EMIT;
        end
        ST_POP_RD: begin
          state <= ST_POP_OUT;
        end
        ST_POP_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            o_tx     <= TX_NONE;
            o_char   <= q_rd_data;
            o_cv     <= 1'b1;
            o_last   <= (pidx == plen - LEN_W'(1));
            o_conn   <= link_up;
            o_lines  <= 3'(queue_count);
            o_drop   <= 1'b0;
            if (pidx == plen - LEN_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              pidx  <= pidx + LEN_W'(1);
              state <= ST_POP_RD;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            o_tx     <= res_tx;
            o_char   <= 8'd0;
            o_cv     <= 1'b0;
            o_last   <= 1'b1;
            o_conn   <= link_up;
            o_lines  <= 3'(queue_count);
            o_drop   <= res_drop;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {o_drop, o_lines, o_conn, o_char, o_tx};
  assign m_tuser = o_cv;
  assign m_tlast = o_last;

  `ULLH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
  `ULLH_ASSERT_IMP(a_count_bound, 1'b1, queue_count <= FULL_CNT, "queue count above depth")
  `ULLH_ASSERT_IMP(a_copy_room, state == ST_COPY, queue_count < FULL_CNT, "copy into full queue")
  `ULLH_ASSERT_IMP(a_pop_index, state == ST_POP_OUT, pidx < plen, "pop index past line length")

endmodule
